[rtl/itda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants and types for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int NUM_DIGITS  = 20;
	localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT
	} state_t;

endpackage

[rtl/itda_dabble_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_dabble_step
// One shift-add-3 step: corrects every BCD digit, then shifts in one bit.
// ----------------------------------------------------------------------------
module itda_dabble_step import itda_pkg::*; (
	input  logic [BCD_WIDTH-1:0] bcd,
	input  logic                 bit_in,
	output logic [BCD_WIDTH-1:0] bcd_next
);

	logic [BCD_WIDTH-1:0] adj;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adj[BCD_WIDTH-2:0], bit_in};

endmodule

[rtl/int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed binary to decimal ASCII text, most significant character first.
//
// channel  | handshake          | payload
// ---------+--------------------+----------------------
// item in  | start, busy        | value
// char out | char_valid strobe  | char_code, last
//
// An item runs bit-serial double dabble over VALUE_WIDTH bits through one
// shared shift-add-3 unit, then an optional sign step for a negative item,
// then a digit scan over NUM_DIGITS digits (leading zeros are skipped
// without a strobe). Each char is registered and shown for one cycle; the
// receiver cannot stall. Reset returns to idle.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii import itda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	output logic        char_valid,
	output logic [5:0]  char_code,
	output logic        last
);

	state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_WIDTH-1:0]   bcd_q, bcd_step;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic                   neg_q, lead_q;
	logic                   char_valid_q, last_q;
	logic [5:0]             char_code_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic                   raw_neg;
	logic [3:0]             top_digit;
	logic                   conv_done, dig_final;
	logic                   emit;
	logic [5:0]             char_d;
	logic                   last_d;

	assign raw       = value[VALUE_WIDTH-1:0];
	assign raw_neg   = raw[VALUE_WIDTH-1];
	assign top_digit = bcd_q[BCD_WIDTH-1 -: 4];
	assign conv_done = (bit_cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1));
	assign dig_final = (dig_cnt_q == DIG_CNT_W'(1));

	itda_dabble_step u_step (
		.bcd      (bcd_q),
		.bit_in   (bin_q[VALUE_WIDTH-1]),
		.bcd_next (bcd_step)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = neg_q ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (dig_final) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit   = 1'b0;
		char_d = CHAR_ZERO;
		last_d = 1'b0;
		case (state_q)
			ST_SIGN: begin
				emit   = 1'b1;
				char_d = CHAR_MINUS;
			end
			ST_DIGIT: begin
				emit   = lead_q || (top_digit != 4'd0) || dig_final;
				char_d = CHAR_ZERO + {2'b00, top_digit};
				last_d = dig_final;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			char_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			char_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		char_code_q <= char_d;
		last_q      <= last_d;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					neg_q     <= raw_neg;
					bin_q     <= raw_neg ? (~raw + VALUE_WIDTH'(1)) : raw;
					bcd_q     <= '0;
					bit_cnt_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q     <= bcd_step;
				bin_q     <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
				lead_q    <= 1'b0;
			end
			ST_DIGIT: begin
				bcd_q     <= {bcd_q[BCD_WIDTH-5:0], 4'd0};
				dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
				if (emit) lead_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign char_valid = char_valid_q;
	assign char_code  = char_code_q;
	assign last       = last_q;

endmodule
